// ----- rtl/mvt_pkg.sv -----
// Shared constants for the motion variation tracker.
// No dependencies; imported by motion_variation_tracker.
package mvt_pkg;

    localparam int SAMPLE_W             = 16;               // raw axis sample
    localparam int AXES                 = 3;                // axes per sensor
    localparam int MAG_W                = 20;               // magnitude, 4 fraction bits
    localparam int FRAC_BITS            = 4;
    localparam int PROD_W               = 2 * SAMPLE_W - 1; // one axis squared, unsigned
    localparam int SUM_W                = 2 * SAMPLE_W;     // sum of three squares
    localparam int RAD_W                = 2 * MAG_W;        // square-root radicand
    localparam int REM_W                = MAG_W + 2;        // square-root remainder
    localparam int SLOT_OUT_W           = 5;                // slot field of a result
    localparam int IN_DATA_W            = 2 * AXES * SAMPLE_W;
    localparam int OUT_DATA_W           = 48;               // 45 bits of fields, byte padded
    localparam int WINDOW_DEPTH_DEFAULT = 32;

endpackage

// ----- rtl/motion_variation_tracker.sv -----
// Motion variation tracker: top level with sequencer, shared squarer and square-root unit.
// Depends on mvt_pkg.

// Each input transfer carries one raw three-axis accelerometer sample and one raw three-axis
// gyroscope sample. The block forms each vector magnitude floor(sqrt(x^2+y^2+z^2)) with
// 4 fraction bits, writes both magnitudes into two ring windows of WINDOW_DEPTH entries at a
// shared slot, then walks the windows from slot 0 up to and including the new slot. Per
// channel it reports the largest minus the smallest absolute change between neighbouring
// entries; with the new sample in slot 0 there is no pair and the variation is 0. The slot
// then advances, wrapping at WINDOW_DEPTH. One item at a time: the next item can be accepted
// once the result has been loaded into the output register (one 16x16 squarer, one axis at a
// time, and a 20-step bit-per-cycle square root, each run once per sensor, then a write of
// both magnitudes, the window walk through the single registered read port, and the load of
// the output register). s_tready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next item may be accepted while it waits. Results
// stay in raw sensor units, scaling is left to software.
// Windows are not cleared after reset: the walk reads only slots written since reset, as the
// slot starts at 0 and advances by one per item.
module motion_variation_tracker
    import mvt_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // fields from bit 0 up: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // fields from bit 0 up: accel_variation (20), gyro_variation (20), slot_written (5),
    // then 3 zero bits
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = ($clog2(WINDOW_DEPTH + 2) > 5) ? $clog2(WINDOW_DEPTH + 2) : 5;
    localparam int ENTRY_W = 2 * MAG_W;
    localparam int PAD_W   = OUT_DATA_W - 2 * MAG_W - SLOT_OUT_W;

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SQRT  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(AXES);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(MAG_W - 1);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW_DEPTH - 1);

    // Control registers
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sensor_reg, sensor_next;       // 0 accel, 1 gyro
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Datapath registers
    logic [IN_DATA_W-1:0]  samp_reg, samp_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [MAG_W-1:0]      root_reg, root_next;
    logic [MAG_W-1:0]      amag_reg, amag_next;
    logic [MAG_W-1:0]      gmag_reg, gmag_next;
    logic [MAG_W-1:0]      aprev_reg, aprev_next;
    logic [MAG_W-1:0]      gprev_reg, gprev_next;
    logic [MAG_W-1:0]      ahi_reg, ahi_next, alo_reg, alo_next;
    logic [MAG_W-1:0]      ghi_reg, ghi_next, glo_reg, glo_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Window memory: {gyro, accel} magnitudes per slot
    logic [ENTRY_W-1:0] win_mem [WINDOW_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic               win_we;

    // Shared squarer
    logic [2:0]                 axis_sel;
    logic signed [SAMPLE_W-1:0] sq_op;
    logic signed [SUM_W-1:0]    sq_full;
    logic [SUM_W-1:0]           acc_sum;

    // Square-root step
    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    logic             take;

    // Window walk
    logic [MAG_W-1:0] rd_acc, rd_gyr, adiff, gdiff;
    logic [CNT_W-1:0] slot_ext, scan_end;
    logic             out_load;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

    assign axis_sel = sensor_reg ? (cnt_reg[2:0] + 3'(AXES)) : cnt_reg[2:0];
    assign sq_op    = samp_reg[axis_sel * SAMPLE_W +: SAMPLE_W];
    assign sq_full  = sq_op * sq_op;
    assign acc_sum  = acc_reg + SUM_W'(prod_reg);

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = (REM_W + 2)'({root_reg, 2'b01});
    assign take      = (rem_shift >= trial);

    assign rd_acc   = rd_data_reg[MAG_W-1:0];
    assign rd_gyr   = rd_data_reg[ENTRY_W-1:MAG_W];
    assign adiff    = (rd_acc >= aprev_reg) ? (rd_acc - aprev_reg) : (aprev_reg - rd_acc);
    assign gdiff    = (rd_gyr >= gprev_reg) ? (rd_gyr - gprev_reg) : (gprev_reg - rd_gyr);
    assign slot_ext = CNT_W'(slot_reg);
    assign scan_end = slot_ext + CNT_W'(1);

    // Hold the read address on the new slot once the walk has passed it
    assign rd_addr  = (cnt_reg > slot_ext) ? slot_reg : cnt_reg[SLOT_W-1:0];
    assign win_we   = (state_reg == S_WRITE);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign slot_wide = {{SLOT_OUT_W{1'b0}}, slot_reg};

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sensor_next   = sensor_reg;
        slot_next     = slot_reg;
        m_tvalid_next = m_tvalid_reg;
        samp_next     = samp_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        rad_next      = rad_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        amag_next     = amag_reg;
        gmag_next     = gmag_reg;
        aprev_next    = aprev_reg;
        gprev_next    = gprev_reg;
        ahi_next      = ahi_reg;
        alo_next      = alo_reg;
        ghi_next      = ghi_reg;
        glo_next      = glo_reg;
        m_tdata_next  = m_tdata_reg;

        // Drop the result once the sink takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    samp_next   = s_tdata;
                    sensor_next = 1'b0;
                    cnt_next    = '0;
                    acc_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                // Square one axis per cycle; accumulate the previous square
                prod_next = sq_full[PROD_W-1:0];
                if (cnt_reg != '0) begin
                    acc_next = acc_sum;
                end
                if (cnt_reg == MUL_LAST) begin
                    rad_next   = {acc_sum, {(RAD_W - SUM_W){1'b0}}};
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_SQRT: begin
                // One result bit per cycle, two radicand bits consumed
                rad_next = rad_reg << 2;
                if (take) begin
                    rem_next  = REM_W'(rem_shift - trial);
                    root_next = {root_reg[MAG_W-2:0], 1'b1};
                end else begin
                    rem_next  = REM_W'(rem_shift);
                    root_next = {root_reg[MAG_W-2:0], 1'b0};
                end
                if (cnt_reg == SQRT_LAST) begin
                    cnt_next = '0;
                    if (!sensor_reg) begin
                        amag_next   = root_next;
                        sensor_next = 1'b1;
                        acc_next    = '0;
                        state_next  = S_MUL;
                    end else begin
                        gmag_next  = root_next;
                        state_next = S_WRITE;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_WRITE: begin
                ahi_next   = '0;
                alo_next   = '0;
                ghi_next   = '0;
                glo_next   = '0;
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                // Read data here belongs to slot cnt-1
                if (cnt_reg != '0) begin
                    aprev_next = rd_acc;
                    gprev_next = rd_gyr;
                    if (cnt_reg == CNT_W'(2)) begin
                        ahi_next = adiff;
                        alo_next = adiff;
                        ghi_next = gdiff;
                        glo_next = gdiff;
                    end else if (cnt_reg > CNT_W'(2)) begin
                        if (adiff > ahi_reg) ahi_next = adiff;
                        if (adiff < alo_reg) alo_next = adiff;
                        if (gdiff > ghi_reg) ghi_next = gdiff;
                        if (gdiff < glo_reg) glo_next = gdiff;
                    end
                end
                if (cnt_reg == scan_end) begin
                    state_next = S_OUT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_tdata_next  = {{PAD_W{1'b0}}, slot_wide[SLOT_OUT_W-1:0],
                                     ghi_reg - glo_reg, ahi_reg - alo_reg};
                    m_tvalid_next = 1'b1;
                    slot_next     = (slot_reg == SLOT_MAX) ? '0 : slot_reg + SLOT_W'(1);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            sensor_reg   <= 1'b0;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            sensor_reg   <= sensor_next;
            slot_reg     <= slot_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg    <= samp_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        amag_reg    <= amag_next;
        gmag_reg    <= gmag_next;
        aprev_reg   <= aprev_next;
        gprev_reg   <= gprev_next;
        ahi_reg     <= ahi_next;
        alo_reg     <= alo_next;
        ghi_reg     <= ghi_next;
        glo_reg     <= glo_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Window memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[slot_reg] <= {gmag_reg, amag_reg};
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // No second transfer straight after an accepted one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while sequencer busy");

    // Write slot stays inside the window
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_MAX)
        else $error("write slot outside window");

    // Largest change never below smallest once the walk is done
    a_hi_lo_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> ((ahi_reg >= alo_reg) && (ghi_reg >= glo_reg)))
        else $error("variation extremes out of order");

    // A sample in slot 0 has no neighbour pair, so both variations are zero
    a_slot0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (slot_reg == '0)) |=> (m_tdata_reg[2*MAG_W-1:0] == '0))
        else $error("non-zero variation for slot 0");
`endif

endmodule
